>>> design/pcs_pkg.sv
// shared constants and codes for the precharge contactor sequencer
package pcs_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned WaitW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FIRST_WAIT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_WAIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_THIRD_WAIT  = 2'd2;

  localparam logic [WaitW-1:0] FIRST_WAIT_RST  = 16'd15000;
  localparam logic [WaitW-1:0] SECOND_WAIT_RST = 16'd50;
  localparam logic [WaitW-1:0] THIRD_WAIT_RST  = 16'd50;

  // request kinds
  localparam logic REQ_STEP  = 1'b0;
  localparam logic REQ_RESET = 1'b1;

  // commands
  localparam logic [1:0] CMD_NONE      = 2'd0;
  localparam logic [1:0] CMD_EBRAKE    = 2'd1;
  localparam logic [1:0] CMD_DISCHARGE = 2'd2;
  localparam logic [1:0] CMD_LAUNCH    = 2'd3;

  // sequence / motor status
  localparam logic [1:0] ST_WAITING  = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_FAILED   = 2'd2;

  // next top-level state
  localparam logic [2:0] NS_PRECHARGE = 3'd0;
  localparam logic [2:0] NS_ESTOP     = 3'd1;
  localparam logic [2:0] NS_DISCHARGE = 3'd2;
  localparam logic [2:0] NS_ENABLE    = 3'd3;
  localparam logic [2:0] NS_STANDBY   = 3'd4;

  // contactor drive bits
  localparam int unsigned K1_IDX = 0;
  localparam int unsigned K2_IDX = 1;
  localparam int unsigned K3_IDX = 2;
  localparam int unsigned K4_IDX = 3;

  typedef struct packed {
    logic       brakes_retract;
    logic [3:0] contactor;
    logic [1:0] sequence_status;
    logic [2:0] next_state;
  } result_t;

endpackage

>>> design/precharge_contactor_sequencer.sv
// precharge contactor sequencer: input register, step logic, result register
//
// Usage: one stream transaction in on s_axis per control step, one stream
// transaction out on m_axis per step, in order.
//   s_axis_tuser_i carries req_type (0 step, 1 sequence reset).
//   s_axis_tdata_i carries command, current_time, motor precharge status and
//   the write-fault flag; m_axis_tdata_o carries next_state, sequence_status,
//   the K1..K4 drive and brakes_retract.
// The step sits in the input register, then the step logic loads the
// result register; a stall on m_axis_tready_i can hold it in the input
// register. Throughput is one step per cycle while m_axis_tready_i is
// high; the deadline adders and compares sit between the input register
// and the result register and update the sequence state in the same
// cycle the result is registered. Wait registers are written on cfg_we_i;
// the user must write them only while the block is idle, as the block does
// not enforce it; index 3 is ignored.
// Reset opens all contactors, disarms every deadline and loads the default
// wait times. When m_axis_tready_i is low the result is held, the input
// register still fills, and s_axis_tready_o drops only when both are full.
module precharge_contactor_sequencer
  import pcs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [WaitW-1:0]    cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [1:0] command, [33:2] current_time, [35:34] motor_precharge_status,
  // [36] write_fault, [39:37] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [0] req_type
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [2:0] next_state, [4:3] sequence_status, [5] contactor_k1,
  // [6] contactor_k2, [7] contactor_k3, [8] contactor_k4,
  // [9] brakes_retract, [15:10] zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [WaitW-1:0] first_wait_q, second_wait_q, third_wait_q;

  logic             in_valid_q;
  logic             in_req_q;
  logic [1:0]       in_cmd_q;
  logic [TimeW-1:0] in_time_q;
  logic [1:0]       in_motor_q;
  logic             in_fault_q;

  logic    out_valid_q;
  result_t out_res_q, out_res_d;

  logic [TimeW-1:0] first_dl_q, first_dl_d;
  logic [TimeW-1:0] second_dl_q, second_dl_d;
  logic [TimeW-1:0] third_dl_q, third_dl_d;
  logic             first_arm_q, first_arm_d;
  logic             second_arm_q, second_arm_d;
  logic             third_arm_q, third_arm_d;
  logic             done_q, done_d;
  logic [3:0]       drive_q, drive_d;

  logic             out_adv;
  logic             fire;
  logic [1:0]       adv_status;
  logic [TimeW-1:0] sum_first, sum_second, sum_third;

  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && out_adv;
  assign s_axis_tready_o = !in_valid_q || out_adv;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_wait_q  <= FIRST_WAIT_RST;
      second_wait_q <= SECOND_WAIT_RST;
      third_wait_q  <= THIRD_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_WAIT:  first_wait_q  <= cfg_data_i;
        CFG_SECOND_WAIT: second_wait_q <= cfg_data_i;
        CFG_THIRD_WAIT:  third_wait_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_req_q   <= s_axis_tuser_i;
      in_cmd_q   <= s_axis_tdata_i[1:0];
      in_time_q  <= s_axis_tdata_i[33:2];
      in_motor_q <= s_axis_tdata_i[35:34];
      in_fault_q <= s_axis_tdata_i[36];
    end
  end

  assign sum_first  = in_time_q + {{(TimeW-WaitW){1'b0}}, first_wait_q};
  assign sum_second = in_time_q + {{(TimeW-WaitW){1'b0}}, second_wait_q};
  assign sum_third  = in_time_q + {{(TimeW-WaitW){1'b0}}, third_wait_q};

  // step logic
  always_comb begin
    first_dl_d   = first_dl_q;
    second_dl_d  = second_dl_q;
    third_dl_d   = third_dl_q;
    first_arm_d  = first_arm_q;
    second_arm_d = second_arm_q;
    third_arm_d  = third_arm_q;
    done_d       = done_q;
    drive_d      = drive_q;
    adv_status   = ST_WAITING;
    out_res_d    = '0;
    out_res_d.next_state      = NS_PRECHARGE;
    out_res_d.sequence_status = ST_WAITING;

    if (in_req_q == REQ_RESET) begin
      first_arm_d  = 1'b0;
      second_arm_d = 1'b0;
      third_arm_d  = 1'b0;
      done_d       = 1'b0;
      if (in_fault_q) begin
        out_res_d.sequence_status = ST_FAILED;
      end else begin
        drive_d                   = '0;
        out_res_d.sequence_status = ST_COMPLETE;
      end
    end else if (in_cmd_q == CMD_EBRAKE) begin
      out_res_d.next_state = NS_ESTOP;
    end else begin
      out_res_d.brakes_retract = !in_fault_q;
      if (in_cmd_q == CMD_DISCHARGE) begin
        out_res_d.next_state = NS_DISCHARGE;
      end else begin
        if (done_q) begin
          adv_status = ST_COMPLETE;
        end else if (!first_arm_q) begin
          if (in_fault_q) begin
            adv_status = ST_FAILED;
          end else begin
            drive_d     = '0;
            drive_d[K4_IDX] = 1'b1;
            first_dl_d  = sum_first;
            first_arm_d = 1'b1;
          end
        end else if (in_time_q == first_dl_q) begin
          if (in_fault_q) begin
            adv_status = ST_FAILED;
          end else begin
            drive_d[K4_IDX] = 1'b0;
            drive_d[K3_IDX] = 1'b1;
            second_dl_d     = sum_second;
            second_arm_d    = 1'b1;
          end
        end else if (second_arm_q && in_time_q == second_dl_q) begin
          if (in_fault_q) begin
            adv_status = ST_FAILED;
          end else begin
            drive_d[K2_IDX] = 1'b1;
          end
        end else if (second_arm_q && in_time_q > second_dl_q &&
                     in_motor_q != ST_COMPLETE) begin
          adv_status = (in_motor_q == ST_WAITING) ? ST_WAITING : ST_FAILED;
        end else if (!third_arm_q && second_arm_q && in_time_q > second_dl_q) begin
          if (in_fault_q) begin
            adv_status = ST_FAILED;
          end else begin
            drive_d[K1_IDX] = 1'b1;
            third_dl_d      = sum_third;
            third_arm_d     = 1'b1;
          end
        end else if (third_arm_q && in_time_q == third_dl_q) begin
          if (in_fault_q) begin
            adv_status = ST_FAILED;
          end else begin
            drive_d[K1_IDX] = 1'b1;
            done_d          = 1'b1;
            adv_status      = ST_COMPLETE;
          end
        end
        out_res_d.sequence_status = adv_status;
        if (adv_status == ST_COMPLETE && in_cmd_q == CMD_LAUNCH) begin
          out_res_d.next_state = in_fault_q ? NS_STANDBY : NS_ENABLE;
        end
      end
    end
    out_res_d.contactor = drive_d;
  end

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_arm_q  <= 1'b0;
      second_arm_q <= 1'b0;
      third_arm_q  <= 1'b0;
      done_q       <= 1'b0;
      drive_q      <= '0;
    end else if (fire) begin
      first_arm_q  <= first_arm_d;
      second_arm_q <= second_arm_d;
      third_arm_q  <= third_arm_d;
      done_q       <= done_d;
      drive_q      <= drive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      first_dl_q  <= first_dl_d;
      second_dl_q <= second_dl_d;
      third_dl_q  <= third_dl_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= out_res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-$bits(result_t)){1'b0}}, out_res_q};

endmodule

>>> design/pcs_checker.sv
// port-level checker for the precharge contactor sequencer, with its bind
module pcs_checker
  import pcs_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [2:0] next_state;
  logic [1:0] seq_status;
  logic       k3, k4, brakes;

  assign next_state = m_axis_tdata_o[2:0];
  assign seq_status = m_axis_tdata_o[4:3];
  assign k3         = m_axis_tdata_o[7];
  assign k4         = m_axis_tdata_o[8];
  assign brakes     = m_axis_tdata_o[9];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // k3 and k4 are never closed together
  a_k3_k4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(k3 && k4))
    else $error("k3 and k4 both closed");

  // motor enable only on a completed sequence with brakes retracted
  a_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && next_state == NS_ENABLE |->
      seq_status == ST_COMPLETE && brakes)
    else $error("enable without completed sequence");

  // brakes never retract on estop or standby
  a_brakes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && brakes |->
      next_state != NS_ESTOP && next_state != NS_STANDBY)
    else $error("brakes retracted on estop or standby");

endmodule

bind precharge_contactor_sequencer pcs_checker u_pcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
